// ----- design/tet_rest_shape_and_lumped_mass_assert.svh -----
// Assertion macros for the block's control module.
// Each macro expects clk and rst_n in scope.
`ifndef TET_REST_SHAPE_AND_LUMPED_MASS_ASSERT_SVH
`define TET_REST_SHAPE_AND_LUMPED_MASS_ASSERT_SVH
`ifndef ASSERT_OFF
`define TRLS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("same-cycle check failed");
`define TRLS_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define TRLS_ASSERT_IMP(lbl, a, b)
`define TRLS_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ----- design/trls_pkg.sv -----
package trls_pkg;

    // store geometry
    localparam int VERTS  = 1024;
    localparam int VIDX_W = 10;

    // wide arithmetic widths
    localparam int DET_W  = 98;
    localparam int DIV_NW = 98;

    // config register
    localparam logic       REG_DENSITY = 1'b0;
    localparam logic [30:0] DENSITY_RST = 31'd65536;

    // volume divisor: 6 * 2^32
    localparam logic signed [DIV_NW-1:0] VOL_DEN = {{(DIV_NW-35){1'b0}}, 3'd6, 32'd0};

    // input actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TET  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_REST = 2'd0;
    localparam logic [1:0] KIND_INV  = 2'd1;
    localparam logic [1:0] KIND_MASS = 2'd2;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_VWRITE,
        OP_MREAD_Q,
        OP_EMIT_Q,
        OP_VREAD,
        OP_VLATCH,
        OP_MUL_COF,
        OP_ACC_COF,
        OP_MUL_DET,
        OP_ACC_DET,
        OP_DIV_VOL,
        OP_WAIT_VOL,
        OP_EMIT_REST,
        OP_DIV_INV,
        OP_WAIT_INV,
        OP_EMIT_INV,
        OP_MUL_MASS,
        OP_LATCH_INC,
        OP_MREAD_C,
        OP_MWRITE_C,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [VIDX_W-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
        logic deg;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] r;
        logic [1:0] c;
    } rc_t;

    typedef struct packed {
        logic [1:0] a;
        logic [1:0] b;
    } pair_t;

    // flat 3x3 position to row and column
    function automatic rc_t rc_of(input logic [3:0] j);
        rc_t v;
        unique case (j)
            4'd0:    v = '{r: 2'd0, c: 2'd0};
            4'd1:    v = '{r: 2'd0, c: 2'd1};
            4'd2:    v = '{r: 2'd0, c: 2'd2};
            4'd3:    v = '{r: 2'd1, c: 2'd0};
            4'd4:    v = '{r: 2'd1, c: 2'd1};
            4'd5:    v = '{r: 2'd1, c: 2'd2};
            4'd6:    v = '{r: 2'd2, c: 2'd0};
            4'd7:    v = '{r: 2'd2, c: 2'd1};
            4'd8:    v = '{r: 2'd2, c: 2'd2};
            default: v = '{r: 2'd0, c: 2'd0};
        endcase
        return v;
    endfunction

    // the two indexes left when one is struck from 0..2
    function automatic pair_t minor_of(input logic [1:0] k);
        pair_t v;
        unique case (k)
            2'd0:    v = '{a: 2'd1, b: 2'd2};
            2'd1:    v = '{a: 2'd0, b: 2'd2};
            2'd2:    v = '{a: 2'd0, b: 2'd1};
            default: v = '{a: 2'd1, b: 2'd2};
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] s;
        if (v[32] != v[31]) begin
            s = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

endpackage

// ----- design/trls_ram.sv -----
module trls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/trls_div.sv -----
module trls_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [trls_pkg::DIV_NW-1:0]  num,
    input  logic signed [trls_pkg::DIV_NW-1:0]  den,
    output logic                                done,
    output logic signed [31:0]                  quo
);

    localparam int NW = trls_pkg::DIV_NW;

    logic          busy_reg;
    logic          done_reg;
    logic [5:0]    cnt_reg;
    logic [NW-1:0] rem_reg;
    logic [NW+31:0] dsh_reg;
    logic [31:0]   q_reg;
    logic          ovf_reg;
    logic          neg_reg;

    logic [NW-1:0] num_mag;
    logic [NW-1:0] den_mag;
    logic          ge;

    // operand magnitudes and trial compare
    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign den_mag = den[NW-1] ? NW'(-den) : NW'(den);
    assign ge      = {32'd0, rem_reg} >= dsh_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring steps, one quotient bit per cycle; first step checks overflow
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num_mag;
            dsh_reg <= {den_mag, 32'd0};
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            neg_reg <= num[NW-1] ^ den[NW-1];
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (cnt_reg == 6'd32)
            begin
                ovf_reg <= ge;
            end
            else
            begin
                q_reg <= {q_reg[30:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg[NW-1:0];
                end
            end
        end
    end

    // sign and saturation
    always_comb
    begin
        if (neg_reg)
        begin
            if (ovf_reg || q_reg > 32'h80000000)
                quo = 32'sh80000000;
            else
                quo = -q_reg;
        end
        else
        begin
            if (ovf_reg || q_reg[31])
                quo = 32'sh7fffffff;
            else
                quo = q_reg;
        end
    end

    assign done = done_reg;

endmodule

// ----- design/trls_dp.sv -----
module trls_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  trls_pkg::dp_cmd_t             cmd,
    output trls_pkg::dp_status_t          status,
    input  logic [30:0]                   density,
    input  logic [9:0]                    vertex_index,
    input  logic signed [31:0]            pos_x,
    input  logic signed [31:0]            pos_y,
    input  logic signed [31:0]            pos_z,
    input  logic [9:0]                    corner0,
    input  logic [9:0]                    corner1,
    input  logic [9:0]                    corner2,
    input  logic [9:0]                    corner3,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    kind,
    output logic [1:0]                    row,
    output logic signed [31:0]            col_a,
    output logic signed [31:0]            col_b,
    output logic signed [31:0]            col_c,
    output logic signed [31:0]            volume,
    output logic [47:0]                   mass_value,
    output logic                          degenerate,
    output logic                          last
);

    localparam int VW = trls_pkg::VIDX_W;
    localparam int DW = trls_pkg::DET_W;
    localparam int NW = trls_pkg::DIV_NW;

    // captured word
    logic [VW-1:0]      vidx_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [VW-1:0]      corner_reg [4];

    // arithmetic state
    logic signed [31:0] base_reg [3];
    logic signed [31:0] m_reg [3][3];
    logic signed [63:0] cof_reg [3][3];
    logic signed [64:0] prod_reg;
    logic signed [64:0] acc_reg;
    logic signed [DW-1:0] det_reg;
    logic signed [31:0] vol_reg;
    logic signed [31:0] e_reg [3];
    logic [47:0]        inc_reg;
    logic               out_valid_reg;

    // memories
    logic               v_we, v_re, m_we, m_re;
    logic [VW-1:0]      v_waddr, v_raddr, m_waddr, m_raddr;
    logic [95:0]        v_rd;
    logic [47:0]        m_rd, m_wdata;
    logic [48:0]        m_sum;
    logic [VW-1:0]      corner_sel;

    // divider
    logic               div_start, div_done;
    logic signed [NW-1:0] div_num, div_den;
    logic signed [31:0] div_quo;

    // decoded pieces
    trls_pkg::rc_t      rc;
    trls_pkg::pair_t    mr, mc;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] prod_next;
    logic signed [64:0] cof_val;
    logic signed [DW-1:0] det_term;
    logic               deg;
    logic               emit;

    assign corner_sel = corner_reg[cmd.idx[1:0]];
    assign deg        = det_reg[DW-1] || (det_reg == '0);
    assign emit       = (cmd.op == trls_pkg::OP_EMIT_REST) || (cmd.op == trls_pkg::OP_EMIT_INV)
                        || (cmd.op == trls_pkg::OP_EMIT_Q);

    // step decode: cofactor steps use idx[4:1], inverse steps use idx[3:0]
    always_comb
    begin
        if (cmd.op == trls_pkg::OP_MUL_COF || cmd.op == trls_pkg::OP_ACC_COF)
            rc = trls_pkg::rc_of(cmd.idx[4:1]);
        else
            rc = trls_pkg::rc_of(cmd.idx[3:0]);
        mr = trls_pkg::minor_of(rc.r);
        mc = trls_pkg::minor_of(rc.c);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            trls_pkg::OP_MUL_COF:
            begin
                if (!cmd.idx[0])
                begin
                    mul_a = 33'(m_reg[mr.a][mc.a]);
                    mul_b = m_reg[mr.b][mc.b];
                end
                else
                begin
                    mul_a = 33'(m_reg[mr.a][mc.b]);
                    mul_b = m_reg[mr.b][mc.a];
                end
            end
            trls_pkg::OP_MUL_DET:
            begin
                if (!cmd.idx[0])
                    mul_a = {1'b0, cof_reg[0][cmd.idx[2:1]][31:0]};
                else
                    mul_a = {cof_reg[0][cmd.idx[2:1]][63], cof_reg[0][cmd.idx[2:1]][63:32]};
                mul_b = m_reg[0][cmd.idx[2:1]];
            end
            trls_pkg::OP_MUL_MASS:
            begin
                mul_a = {2'b00, density};
                mul_b = vol_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // cofactor close-out and determinant term
    assign cof_val  = ((rc.r[0] ^ rc.c[0]) != 1'b0) ? (prod_reg - acc_reg) : (acc_reg - prod_reg);
    assign det_term = cmd.idx[0] ? ({{(DW-65){prod_reg[64]}}, prod_reg} <<< 32)
                                 : {{(DW-65){prod_reg[64]}}, prod_reg};

    // divider operands
    assign div_start = (cmd.op == trls_pkg::OP_DIV_VOL) || (cmd.op == trls_pkg::OP_DIV_INV);
    assign div_num   = (cmd.op == trls_pkg::OP_DIV_VOL) ? NW'(det_reg)
                     : {{(NW-96){cof_reg[rc.c][rc.r][63]}}, cof_reg[rc.c][rc.r], 32'd0};
    assign div_den   = (cmd.op == trls_pkg::OP_DIV_VOL) ? trls_pkg::VOL_DEN : NW'(det_reg);

    trls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // vertex store
    assign v_we    = (cmd.op == trls_pkg::OP_VWRITE);
    assign v_waddr = vidx_reg;
    assign v_re    = (cmd.op == trls_pkg::OP_VREAD);
    assign v_raddr = corner_sel;

    trls_ram #(.WIDTH(96), .DEPTH(trls_pkg::VERTS)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata ({px_reg, py_reg, pz_reg}),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_rd)
    );

    // mass store: clear sweep or saturating add
    assign m_sum   = {1'b0, m_rd} + {1'b0, inc_reg};
    assign m_we    = (cmd.op == trls_pkg::OP_CLEAR) || (cmd.op == trls_pkg::OP_MWRITE_C);
    assign m_waddr = (cmd.op == trls_pkg::OP_CLEAR) ? cmd.idx : corner_sel;
    assign m_wdata = (cmd.op == trls_pkg::OP_CLEAR) ? 48'd0
                   : (m_sum[48] ? {48{1'b1}} : m_sum[47:0]);
    assign m_re    = (cmd.op == trls_pkg::OP_MREAD_Q) || (cmd.op == trls_pkg::OP_MREAD_C);
    assign m_raddr = (cmd.op == trls_pkg::OP_MREAD_Q) ? vidx_reg : corner_sel;

    trls_ram #(.WIDTH(48), .DEPTH(trls_pkg::VERTS)) u_mram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .re    (m_re),
        .raddr (m_raddr),
        .rdata (m_rd)
    );

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            trls_pkg::OP_CAPTURE:
            begin
                vidx_reg      <= vertex_index;
                px_reg        <= pos_x;
                py_reg        <= pos_y;
                pz_reg        <= pos_z;
                corner_reg[0] <= corner0;
                corner_reg[1] <= corner1;
                corner_reg[2] <= corner2;
                corner_reg[3] <= corner3;
            end
            trls_pkg::OP_VLATCH:
            begin
                if (cmd.idx[1:0] == 2'd0)
                begin
                    base_reg[0] <= v_rd[95:64];
                    base_reg[1] <= v_rd[63:32];
                    base_reg[2] <= v_rd[31:0];
                end
                else
                begin
                    m_reg[0][cmd.idx[1:0] - 2'd1] <= trls_pkg::sat32(
                        33'(signed'(v_rd[95:64])) - 33'(base_reg[0]));
                    m_reg[1][cmd.idx[1:0] - 2'd1] <= trls_pkg::sat32(
                        33'(signed'(v_rd[63:32])) - 33'(base_reg[1]));
                    m_reg[2][cmd.idx[1:0] - 2'd1] <= trls_pkg::sat32(
                        33'(signed'(v_rd[31:0])) - 33'(base_reg[2]));
                end
            end
            trls_pkg::OP_MUL_COF, trls_pkg::OP_MUL_DET, trls_pkg::OP_MUL_MASS:
            begin
                prod_reg <= prod_next;
            end
            trls_pkg::OP_ACC_COF:
            begin
                if (!cmd.idx[0])
                    acc_reg <= prod_reg;
                else
                    cof_reg[rc.r][rc.c] <= cof_val[63:0];
            end
            trls_pkg::OP_ACC_DET:
            begin
                if (cmd.idx == '0)
                    det_reg <= det_term;
                else
                    det_reg <= det_reg + det_term;
            end
            trls_pkg::OP_WAIT_VOL:
            begin
                if (div_done)
                    vol_reg <= div_quo;
            end
            trls_pkg::OP_WAIT_INV:
            begin
                if (div_done)
                    e_reg[rc.c] <= div_quo;
            end
            trls_pkg::OP_LATCH_INC:
            begin
                inc_reg <= {1'b0, prod_reg[64:18]};
            end
            default:
            begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            trls_pkg::OP_EMIT_REST:
            begin
                kind       <= trls_pkg::KIND_REST;
                row        <= cmd.idx[1:0];
                col_a      <= m_reg[cmd.idx[1:0]][0];
                col_b      <= m_reg[cmd.idx[1:0]][1];
                col_c      <= m_reg[cmd.idx[1:0]][2];
                volume     <= vol_reg;
                mass_value <= '0;
                degenerate <= deg;
                last       <= 1'b0;
            end
            trls_pkg::OP_EMIT_INV:
            begin
                kind       <= trls_pkg::KIND_INV;
                row        <= rc.r;
                col_a      <= deg ? 32'sd0 : e_reg[0];
                col_b      <= deg ? 32'sd0 : e_reg[1];
                col_c      <= deg ? 32'sd0 : e_reg[2];
                volume     <= vol_reg;
                mass_value <= '0;
                degenerate <= deg;
                last       <= (rc.r == 2'd2);
            end
            trls_pkg::OP_EMIT_Q:
            begin
                kind       <= trls_pkg::KIND_MASS;
                row        <= 2'd0;
                col_a      <= '0;
                col_b      <= '0;
                col_c      <= '0;
                volume     <= '0;
                mass_value <= m_rd;
                degenerate <= 1'b0;
                last       <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid       = out_valid_reg;
    assign status.out_free = !out_valid_reg || !out_stall;
    assign status.div_done = div_done;
    assign status.deg      = deg;

endmodule

// ----- design/trls_ctrl.sv -----
`include "tet_rest_shape_and_lumped_mass_assert.svh"

module trls_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            action,
    output logic                  in_stall,
    input  trls_pkg::dp_status_t  status,
    output trls_pkg::dp_cmd_t     cmd
);

    localparam int VW = trls_pkg::VIDX_W;

    typedef enum logic [20:0] {
        S_CLR    = 21'h000001,
        S_IDLE   = 21'h000002,
        S_LOAD   = 21'h000004,
        S_QRD    = 21'h000008,
        S_QEMIT  = 21'h000010,
        S_VRD    = 21'h000020,
        S_VLAT   = 21'h000040,
        S_MUL    = 21'h000080,
        S_ACC    = 21'h000100,
        S_DMUL   = 21'h000200,
        S_DACC   = 21'h000400,
        S_VDIV   = 21'h000800,
        S_VWAIT  = 21'h001000,
        S_EMIT_R = 21'h002000,
        S_IDIV   = 21'h004000,
        S_IWAIT  = 21'h008000,
        S_EMIT_I = 21'h010000,
        S_MMUL   = 21'h020000,
        S_MLAT   = 21'h040000,
        S_MRD    = 21'h080000,
        S_MWR    = 21'h100000
    } state_t;

    state_t          state_reg, state_next;
    logic [VW-1:0]   cnt_reg, cnt_next;
    trls_pkg::rc_t   iw_rc;

    // row and column of the inverse entry in progress
    assign iw_rc = trls_pkg::rc_of(cnt_reg[3:0]);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = trls_pkg::OP_NOP;
        cmd.idx    = cnt_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = trls_pkg::OP_CLEAR;
                if (cnt_reg == VW'(trls_pkg::VERTS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + VW'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op   = trls_pkg::OP_CAPTURE;
                    cnt_next = '0;
                    case (action)
                        trls_pkg::ACT_LOAD: state_next = S_LOAD;
                        trls_pkg::ACT_TET:  state_next = S_VRD;
                        trls_pkg::ACT_READ: state_next = S_QRD;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.op     = trls_pkg::OP_VWRITE;
                state_next = S_IDLE;
            end
            S_QRD:
            begin
                cmd.op     = trls_pkg::OP_MREAD_Q;
                state_next = S_QEMIT;
            end
            S_QEMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op     = trls_pkg::OP_EMIT_Q;
                    state_next = S_IDLE;
                end
            end
            S_VRD:
            begin
                cmd.op     = trls_pkg::OP_VREAD;
                state_next = S_VLAT;
            end
            S_VLAT:
            begin
                cmd.op = trls_pkg::OP_VLATCH;
                if (cnt_reg == VW'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + VW'(1);
                    state_next = S_VRD;
                end
            end
            S_MUL:
            begin
                cmd.op     = trls_pkg::OP_MUL_COF;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = trls_pkg::OP_ACC_COF;
                if (cnt_reg == VW'(17))
                begin
                    cnt_next   = '0;
                    state_next = S_DMUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + VW'(1);
                    state_next = S_MUL;
                end
            end
            S_DMUL:
            begin
                cmd.op     = trls_pkg::OP_MUL_DET;
                state_next = S_DACC;
            end
            S_DACC:
            begin
                cmd.op = trls_pkg::OP_ACC_DET;
                if (cnt_reg == VW'(5))
                begin
                    cnt_next   = '0;
                    state_next = S_VDIV;
                end
                else
                begin
                    cnt_next   = cnt_reg + VW'(1);
                    state_next = S_DMUL;
                end
            end
            S_VDIV:
            begin
                cmd.op     = trls_pkg::OP_DIV_VOL;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                cmd.op = trls_pkg::OP_WAIT_VOL;
                if (status.div_done)
                begin
                    cnt_next   = '0;
                    state_next = S_EMIT_R;
                end
            end
            S_EMIT_R:
            begin
                if (status.out_free)
                begin
                    cmd.op = trls_pkg::OP_EMIT_REST;
                    if (cnt_reg == VW'(2))
                    begin
                        // degenerate: inverse rows are zero, one emit per row
                        cnt_next   = status.deg ? VW'(2) : '0;
                        state_next = status.deg ? S_EMIT_I : S_IDIV;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + VW'(1);
                    end
                end
            end
            S_IDIV:
            begin
                cmd.op     = trls_pkg::OP_DIV_INV;
                state_next = S_IWAIT;
            end
            S_IWAIT:
            begin
                cmd.op = trls_pkg::OP_WAIT_INV;
                if (status.div_done)
                begin
                    if (iw_rc.c == 2'd2)
                    begin
                        state_next = S_EMIT_I;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + VW'(1);
                        state_next = S_IDIV;
                    end
                end
            end
            S_EMIT_I:
            begin
                if (status.out_free)
                begin
                    cmd.op = trls_pkg::OP_EMIT_INV;
                    if (cnt_reg == VW'(8))
                    begin
                        cnt_next   = '0;
                        state_next = status.deg ? S_IDLE : S_MMUL;
                    end
                    else if (status.deg)
                    begin
                        cnt_next = cnt_reg + VW'(3);
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + VW'(1);
                        state_next = S_IDIV;
                    end
                end
            end
            S_MMUL:
            begin
                cmd.op     = trls_pkg::OP_MUL_MASS;
                state_next = S_MLAT;
            end
            S_MLAT:
            begin
                cmd.op     = trls_pkg::OP_LATCH_INC;
                cnt_next   = '0;
                state_next = S_MRD;
            end
            S_MRD:
            begin
                cmd.op     = trls_pkg::OP_MREAD_C;
                state_next = S_MWR;
            end
            S_MWR:
            begin
                cmd.op = trls_pkg::OP_MWRITE_C;
                if (cnt_reg == VW'(3))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + VW'(1);
                    state_next = S_MRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

    // checks
    `TRLS_ASSERT_IMP(a_emit_free, (cmd.op == trls_pkg::OP_EMIT_REST || cmd.op == trls_pkg::OP_EMIT_INV || cmd.op == trls_pkg::OP_EMIT_Q), status.out_free)
    `TRLS_ASSERT_IMP(a_mass_not_deg, (state_reg == S_MWR || state_reg == S_MMUL), !status.deg)
    `TRLS_ASSERT_NXT(a_vwait_hold, (state_reg == S_VWAIT && !status.div_done), state_reg == S_VWAIT)

endmodule

// ----- design/tet_rest_shape_and_lumped_mass.sv -----
// Load: captured on accept, written to the vertex store in S_LOAD, next word taken in S_IDLE.
// Mass read: memory read in S_QRD, result word emitted from S_QEMIT once the output is free,
// then the next word taken. Tetrahedron: no word taken until done; radix-2 divisions for
// the volume and nine inverse entries, 25 products of the single shared multiplier and four
// mass read-modify-writes (degenerate: the volume division and 24 products only).
// Reset is asynchronous, active low; afterwards a 1024-entry sweep clears the mass memory,
// during which no input word is taken (register writes are taken as ever).
module tet_rest_shape_and_lumped_mass (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         action,
    input  logic [9:0]         vertex_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [9:0]         corner0,
    input  logic [9:0]         corner1,
    input  logic [9:0]         corner2,
    input  logic [9:0]         corner3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [1:0]         row,
    output logic signed [31:0] col_a,
    output logic signed [31:0] col_b,
    output logic signed [31:0] col_c,
    output logic signed [31:0] volume,
    output logic [47:0]        mass_value,
    output logic               degenerate,
    output logic               last
);

    logic [30:0]          density_reg;
    logic                 hit;
    trls_pkg::dp_cmd_t    cmd;
    trls_pkg::dp_status_t status;

    // register port
    assign pready = 1'b1;
    assign hit    = (paddr[2] == trls_pkg::REG_DENSITY) && (paddr[1:0] == 2'b00);
    assign prdata = hit ? {1'b0, density_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            density_reg <= trls_pkg::DENSITY_RST;
        else if (psel && penable && pwrite && hit)
            density_reg <= pwdata[30:0];
    end

    trls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    trls_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .density      (density_reg),
        .vertex_index (vertex_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .corner0      (corner0),
        .corner1      (corner1),
        .corner2      (corner2),
        .corner3      (corner3),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .row          (row),
        .col_a        (col_a),
        .col_b        (col_b),
        .col_c        (col_c),
        .volume       (volume),
        .mass_value   (mass_value),
        .degenerate   (degenerate),
        .last         (last)
    );

endmodule

// ----- tb/sv/tet_rest_shape_and_lumped_mass_test.sv -----
module tet_rest_shape_and_lumped_mass_test;
    import trls_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 50;

    typedef struct {
        logic [1:0]         act;
        logic [9:0]         vidx;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic [9:0]         cn [4];
    } tet_word_t;

    typedef struct {
        logic [1:0]         kind;
        logic [1:0]         row;
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] cc;
        logic signed [31:0] vol;
        logic [47:0]        mass;
        logic               deg;
        logic               last;
    } geom_word_t;

    // directed row: typed rows carry their mass readout directly
    typedef struct {
        tet_word_t   w;
        bit          typed;
        logic [47:0] mass;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = '0;
    logic [9:0] vertex_index = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic [9:0] corner0 = '0;
    logic [9:0] corner1 = '0;
    logic [9:0] corner2 = '0;
    logic [9:0] corner3 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] kind;
    logic [1:0] row;
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic signed [31:0] volume;
    logic [47:0] mass_value;
    logic degenerate;
    logic last;

    // predictor state
    logic signed [31:0] pos_xs [VERTS];
    logic signed [31:0] pos_ys [VERTS];
    logic signed [31:0] pos_zs [VERTS];
    logic [47:0] vert_mass [VERTS];
    bit loaded [VERTS];
    int loaded_list [$];
    logic [30:0] density_q;

    geom_word_t pending_words [$];
    int errors = 0;
    int words_seen = 0;
    int tets_sent = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold = 0;
    bit hold_req = 0;
    int rs_cnt = 0;

    tet_rest_shape_and_lumped_mass u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .vertex_index(vertex_index),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .corner0(corner0), .corner1(corner1), .corner2(corner2), .corner3(corner3),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .row(row), .col_a(col_a), .col_b(col_b), .col_c(col_c),
        .volume(volume), .mass_value(mass_value), .degenerate(degenerate), .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // clamp to signed Q16.16
    function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sh7fffffff)
            return 32'sh7fffffff;
        if (v < -128'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic geom_word_t mass_word(input logic [47:0] m);
        geom_word_t g;
        g = '{kind: KIND_MASS, row: 2'd0, ca: 0, cb: 0, cc: 0, vol: 0,
              mass: m, deg: 1'b0, last: 1'b1};
        return g;
    endfunction

    // geometry and mass predictor
    task automatic predict_geom(input tet_word_t w);
        logic signed [127:0] p [4][3];
        logic signed [127:0] m [3][3];
        logic signed [127:0] cf [3][3];
        logic signed [127:0] det;
        logic signed [31:0] vol;
        logic signed [31:0] e [3];
        logic dg;
        logic [63:0] inc;
        logic [48:0] s;
        int r1, r2, c1, c2;
        case (w.act)
            ACT_LOAD:
            begin
                pos_xs[w.vidx] = w.px;
                pos_ys[w.vidx] = w.py;
                pos_zs[w.vidx] = w.pz;
                if (!loaded[w.vidx])
                    loaded_list.push_back(w.vidx);
                loaded[w.vidx] = 1;
            end
            ACT_TET:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    p[k][0] = pos_xs[w.cn[k]];
                    p[k][1] = pos_ys[w.cn[k]];
                    p[k][2] = pos_zs[w.cn[k]];
                end
                for (int r = 0; r < 3; r++)
                    for (int c = 0; c < 3; c++)
                        m[r][c] = clamp32(p[c+1][r] - p[0][r]);
                for (int r = 0; r < 3; r++)
                begin
                    r1 = (r == 0) ? 1 : 0;
                    r2 = (r == 2) ? 1 : 2;
                    for (int c = 0; c < 3; c++)
                    begin
                        c1 = (c == 0) ? 1 : 0;
                        c2 = (c == 2) ? 1 : 2;
                        cf[r][c] = m[r1][c1] * m[r2][c2] - m[r1][c2] * m[r2][c1];
                        if ((r + c) % 2 == 1)
                            cf[r][c] = -cf[r][c];
                    end
                end
                det = 0;
                for (int c = 0; c < 3; c++)
                    det = det + cf[0][c] * m[0][c];
                vol = clamp32(det / (128'sd6 <<< 32));
                dg = (det <= 0);
                for (int r = 0; r < 3; r++)
                    pending_words.push_back('{kind: KIND_REST, row: 2'(r),
                        ca: m[r][0][31:0], cb: m[r][1][31:0], cc: m[r][2][31:0],
                        vol: vol, mass: 48'd0, deg: dg, last: 1'b0});
                for (int r = 0; r < 3; r++)
                begin
                    for (int c = 0; c < 3; c++)
                        e[c] = dg ? 32'sd0 : clamp32((cf[c][r] <<< 32) / det);
                    pending_words.push_back('{kind: KIND_INV, row: 2'(r),
                        ca: e[0], cb: e[1], cc: e[2], vol: vol, mass: 48'd0,
                        deg: dg, last: (r == 2)});
                end
                // quarter of element mass to each corner; degenerate elements add none
                if (!dg)
                begin
                    inc = ({32'd0, vol} * {33'd0, density_q}) >> 18;
                    for (int k = 0; k < 4; k++)
                    begin
                        s = {1'b0, vert_mass[w.cn[k]]} + inc[48:0];
                        vert_mass[w.cn[k]] = s[48] ? 48'hffff_ffff_ffff : s[47:0];
                    end
                end
                tets_sent++;
            end
            ACT_READ:
                pending_words.push_back(mass_word(vert_mass[w.vidx]));
            default: ;
        endcase
    endtask

    // offer one word, then an optional idle burst
    task automatic send_word(input tet_word_t w, input bit typed, input logic [47:0] tm);
        int gap;
        action <= w.act;
        vertex_index <= w.vidx;
        pos_x <= w.px;
        pos_y <= w.py;
        pos_z <= w.pz;
        corner0 <= w.cn[0];
        corner1 <= w.cn[1];
        corner2 <= w.cn[2];
        corner3 <= w.cn[3];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (typed)
            pending_words.push_back(mass_word(tm));
        else
            predict_geom(w);
        gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_density(input logic [30:0] v);
        in_valid <= 1'b0;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_DENSITY);
        pwdata <= {1'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        density_q = v;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
            default: v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        endcase
        return v;
    endfunction

    function automatic tet_word_t rand_word();
        tet_word_t w;
        int pick;
        w.act = ACT_LOAD;
        w.vidx = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 31)) : 10'($urandom);
        w.px = rand_coord();
        w.py = rand_coord();
        w.pz = rand_coord();
        for (int k = 0; k < 4; k++)
            w.cn[k] = 10'($urandom);
        pick = $urandom_range(0, 99);
        if (pick >= 35 && pick < 75 && loaded_list.size() > 0)
        begin
            w.act = ACT_TET;
            for (int k = 0; k < 4; k++)
                w.cn[k] = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        end
        else if (pick >= 75 && pick < 95)
        begin
            w.act = ACT_READ;
            if (loaded_list.size() > 0 && $urandom_range(0, 1) == 0)
                w.vidx = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        end
        else if (pick >= 95)
        begin
            w.act = ACT_UNUSED;
        end
        return w;
    endfunction

    function automatic tet_word_t mk(input logic [1:0] a, input int vi,
                                     input logic signed [31:0] x, input logic signed [31:0] y,
                                     input logic signed [31:0] z,
                                     input int k0, input int k1, input int k2, input int k3);
        tet_word_t w;
        w.act = a;
        w.vidx = 10'(vi);
        w.px = x;
        w.py = y;
        w.pz = z;
        w.cn[0] = 10'(k0);
        w.cn[1] = 10'(k1);
        w.cn[2] = 10'(k2);
        w.cn[3] = 10'(k3);
        return w;
    endfunction

    // receiver stall bursts, long hold-off on request
    always @(posedge clk)
    begin
        if (hold)
            out_stall <= 1'b1;
        else if (quiet)
            out_stall <= 1'b0;
        else if (rs_cnt > 0)
            rs_cnt <= rs_cnt - 1;
        else
        begin
            out_stall <= ($urandom_range(0, 2) == 0);
            rs_cnt <= $urandom_range(1, 7);
        end
    end

    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // compare each accepted result word with the oldest prediction
    task automatic chk(input string nm, input logic [63:0] ex, input logic [63:0] ac);
        if (ex !== ac)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, nm, ex, ac);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        geom_word_t g;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                $display("%0t unexpected result word kind %0d row %0d", $time, kind, row);
                errors++;
            end
            else
            begin
                g = pending_words.pop_front();
                chk("kind", g.kind, kind);
                chk("row", g.row, row);
                chk("col_a", g.ca, col_a);
                chk("col_b", g.cb, col_b);
                chk("col_c", g.cc, col_c);
                chk("volume", g.vol, volume);
                chk("mass_value", g.mass, mass_value);
                chk("degenerate", g.deg, degenerate);
                chk("last", g.last, last);
            end
        end
    end

    // stimulus
    initial
    begin
        dir_row_t dir [$];
        logic signed [31:0] one;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        one = 32'sh10000;
        hi = 32'sh7fffffff;
        lo = 32'sh80000000;
        for (int i = 0; i < VERTS; i++)
        begin
            vert_mass[i] = '0;
            loaded[i] = 0;
        end
        density_q = DENSITY_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // mass cleared at reset
        dir.push_back('{mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 48'd0});
        dir.push_back('{mk(ACT_READ, 1023, -1, -1, -1, 1023, 1023, 1023, 1023), 1, 48'd0});
        // unit tetrahedron
        dir.push_back('{mk(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_LOAD, 1, one, 0, 0, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_LOAD, 2, 0, one, 0, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_LOAD, 3, 0, 0, one, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_TET, 0, 0, 0, 0, 0, 1, 2, 3), 0, 48'd0});
        // volume 1/6 at unit density: a quarter of it per corner
        dir.push_back('{mk(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, 48'd2730});
        dir.push_back('{mk(ACT_READ, 3, 0, 0, 0, 0, 0, 0, 0), 1, 48'd2730});
        // inverted orientation and a repeated corner are degenerate
        dir.push_back('{mk(ACT_TET, 0, 0, 0, 0, 0, 2, 1, 3), 0, 48'd0});
        dir.push_back('{mk(ACT_TET, 0, 0, 0, 0, 0, 0, 2, 3), 0, 48'd0});
        dir.push_back('{mk(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0), 1, 48'd2730});
        // unused action is dropped
        dir.push_back('{mk(ACT_UNUSED, 1023, hi, lo, -1, 1023, 512, 5, 1023), 0, 48'd0});
        dir.push_back('{mk(ACT_READ, 2, 0, 0, 0, 0, 0, 0, 0), 1, 48'd2730});
        // extreme coordinates, edges saturate
        dir.push_back('{mk(ACT_LOAD, 1020, lo, lo, lo, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_LOAD, 1021, hi, lo, lo, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_LOAD, 1022, lo, hi, lo, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_LOAD, 1023, lo, lo, hi, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_TET, 0, 0, 0, 0, 1020, 1021, 1022, 1023), 0, 48'd0});
        dir.push_back('{mk(ACT_TET, 0, 0, 0, 0, 1023, 1020, 1021, 1022), 0, 48'd0});
        dir.push_back('{mk(ACT_TET, 0, 0, 0, 0, 1, 1021, 3, 1020), 0, 48'd0});
        dir.push_back('{mk(ACT_READ, 1020, 0, 0, 0, 0, 0, 0, 0), 0, 48'd0});
        dir.push_back('{mk(ACT_READ, 1, 0, 0, 0, 0, 0, 0, 0), 0, 48'd0});
        foreach (dir[i])
            send_word(dir[i].w, dir[i].typed, dir[i].mass);
        drain();

        // zero density: volumes but no mass
        write_density(31'd0);
        repeat (120) send_word(rand_word(), 0, 0);
        drain();

        // full density: drive mass to saturation, receiver holds off meanwhile
        write_density(31'h7fffffff);
        hold_req = 1;
        for (int k = 0; k < 4; k++)
            send_word(mk(ACT_LOAD, 1000 + k, (k == 1) ? hi : lo, (k == 2) ? hi : lo,
                         (k == 3) ? hi : lo, 0, 0, 0, 0), 0, 0);
        repeat (20) send_word(mk(ACT_TET, 0, 0, 0, 0, 1000, 1001, 1002, 1003), 0, 0);
        send_word(mk(ACT_READ, 1002, 0, 0, 0, 0, 0, 0, 0), 0, 0);
        repeat (100) send_word(rand_word(), 0, 0);
        drain();

        // random density, sender pauses until results are all back
        write_density(31'($urandom));
        repeat (60) send_word(rand_word(), 0, 0);
        drain();
        repeat (60) send_word(rand_word(), 0, 0);
        drain();

        // last stretch at back-to-back rate
        write_density(31'd3 << 16);
        quiet = 1;
        repeat (100) send_word(rand_word(), 0, 0);
        drain();

        $display("covered %0d tetrahedra, %0d result words, density at zero, unit, full and random",
                 tets_sent, words_seen);
        $display("with stall bursts, one long receiver hold-off and mass saturation");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- tet_rest_shape_and_lumped_mass.f -----
+incdir+design
design/trls_pkg.sv
design/trls_ram.sv
design/trls_div.sv
design/trls_dp.sv
design/trls_ctrl.sv
design/tet_rest_shape_and_lumped_mass.sv
tb/sv/tet_rest_shape_and_lumped_mass_test.sv
